// ===== hw/rtl/vti_pkg.sv =====
// Package for the visibility table interpolator: item types, codes, divider request types
// and the default calibration table.
// No dependencies.
package vti_pkg;

	// Widths fixed by the item fields
	localparam int READING_W = 32;
	localparam int VIS_W     = 17;
	localparam int INDEX_W   = 4;
	localparam int POINTS_W  = 5;

	// Shared divider sizing: sigma and distance quotients reach 3 * 2^32
	localparam int DIV_W  = 34;
	localparam int STEP_W = 6;
	localparam logic [DIV_W-1:0]  SIGMA_NUM   = 34'h3_0000_0000;
	localparam logic [STEP_W-1:0] STEPS_SIGMA = 6'd34;
	localparam logic [STEP_W-1:0] STEPS_FRAC  = 6'd32;

	localparam logic [VIS_W-1:0] VIS_MAX = 17'd131071;

	// Item kinds
	localparam logic KIND_CONVERT = 1'b0;
	localparam logic KIND_LOAD    = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_POINTS        = 2'd0;
	localparam logic [1:0] CFG_FLOOR_READING = 2'd1;
	localparam logic [1:0] CFG_FLOOR_VIS     = 2'd2;

	typedef enum logic [1:0] {
		REG_ABOVE_FIRST = 2'd0,
		REG_BELOW_FLOOR = 2'd1,
		REG_BELOW_LAST  = 2'd2,
		REG_INTERP      = 2'd3
	} region_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE,
		ST_NEXT,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_MUL,
		ST_ADD,
		ST_FINISH
	} seq_state_t;

	typedef enum logic [1:0] {
		OP_SIGMA0,
		OP_SIGMA1,
		OP_FRAC,
		OP_VIS
	} div_op_t;

	typedef struct packed {
		logic                 kind;
		logic [READING_W-1:0] sample_reading;
		logic [INDEX_W-1:0]   entry_index;
		logic [READING_W-1:0] entry_reading;
		logic [VIS_W-1:0]     entry_visibility;
	} in_item_t;

	typedef struct packed {
		logic [VIS_W-1:0] visibility_m;
		region_t          region;
	} out_item_t;

	typedef struct packed {
		logic [READING_W-1:0] reading;
		logic [VIS_W-1:0]     distance;
	} tbl_entry_t;

	// Request to and response from the shared divider
	typedef struct packed {
		logic              go;
		logic [DIV_W-1:0]  rem_init;
		logic [DIV_W-1:0]  num;
		logic [DIV_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
	} div_rsp_t;

	// Default calibration: readings in twentieths, distances in meters
	localparam int DFLT_COUNT = 16;
	localparam logic [21:0] DFLT_X20 [DFLT_COUNT] = '{
		22'd3250000, 22'd130000, 22'd23700, 22'd10600, 22'd3800, 22'd2100,
		22'd1600, 22'd360, 22'd210, 22'd200, 22'd170, 22'd110, 22'd45, 22'd41,
		22'd20, 22'd2
	};
	localparam logic [VIS_W-1:0] DFLT_DIST [DFLT_COUNT] = '{
		17'd5, 17'd20, 17'd110, 17'd230, 17'd600, 17'd980, 17'd1250, 17'd3210,
		17'd5090, 17'd5730, 17'd6280, 17'd9730, 17'd22360, 17'd24720, 17'd38960,
		17'd75000
	};

	// Converts a value in twentieths to the reading format, rounded to nearest.
	function automatic logic [READING_W-1:0] from_x20(input logic [21:0] v, input int frac);
		logic [63:0] s;
		s = ({42'd0, v} << frac) + 64'd10;
		return READING_W'(s / 64'd20);
	endfunction

endpackage

// ===== hw/rtl/vti_table.sv =====
// Calibration table memory: one write port, one registered read port.
// Entries never loaded read as the default calibration. Depends on vti_pkg.
module vti_table import vti_pkg::*; #(
	parameter int TABLE_POINTS      = 16,
	parameter int READING_FRAC_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            wr_en,
	input  logic [$clog2(TABLE_POINTS)-1:0] wr_addr,
	input  tbl_entry_t                      wr_entry,
	input  logic [$clog2(TABLE_POINTS)-1:0] rd_addr,
	output tbl_entry_t                      rd_entry
);

	tbl_entry_t              mem_q [TABLE_POINTS];
	logic [TABLE_POINTS-1:0] vld_q;
	tbl_entry_t              dflt [TABLE_POINTS];
	tbl_entry_t              rd_q;

	// Default contents; slots past the calibration list repeat its last entry.
	for (genvar g = 0; g < TABLE_POINTS; g++) begin : g_dflt
		localparam int K = (g < DFLT_COUNT) ? g : DFLT_COUNT - 1;
		assign dflt[g] = '{reading: from_x20(DFLT_X20[K], READING_FRAC_BITS),
			distance: DFLT_DIST[K]};
	end

	// Valid bits mark entries that have been loaded since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_entry;
		end
		rd_q <= vld_q[rd_addr] ? mem_q[rd_addr] : dflt[rd_addr];
	end

	assign rd_entry = rd_q;

endmodule

// ===== hw/rtl/vti_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on vti_pkg for the request and response types.
module vti_div import vti_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  num_q;
	logic [DIV_W-1:0]  den_q;
	logic [DIV_W-1:0]  quo_q;
	logic [DIV_W:0]    trial;
	logic [DIV_W:0]    diff;
	logic              fits;

	// One trial subtraction of the shifted remainder.
	always_comb begin
		trial = {rem_q, num_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = trial >= {1'b0, den_q};
	end

	// Iteration control; done pulses for one cycle after the last step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == STEP_W'(1));
			if (req.go) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Remainder, dividend and quotient shift registers.
	always_ff @(posedge clk) begin
		if (req.go) begin
			rem_q <= req.rem_init;
			num_q <= req.num;
			den_q <= req.den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

endmodule

// ===== hw/rtl/visibility_table_interpolator_unit.sv =====
// Visibility table interpolator top level: configuration registers, sequencer, datapath
// and result register. Depends on vti_pkg, vti_table and vti_div.
//
// Channel   Handshake                Payload
// item      item_valid / item_stall      in_item_t (convert or load)
// result    result_valid / result_stall  out_item_t (one per convert item)
// cfg       cfg_valid / cfg_ready        cfg_index, cfg_data
//
// A load item writes the table on its transfer and leaves the sequencer idle. A convert
// item scans the n used table entries one per cycle through the table read port; a drain
// and a decide state then settle a result outside the interpolation range. Interpolation
// adds a segment read, up to four shared-divider divisions (34, 34, 32 and 34 steps), a
// multiply and an add; the fraction division is skipped for a reading on the lower entry.
// item_stall is high until the sequencer is idle, which a stalled older result delays.
module visibility_table_interpolator_unit import vti_pkg::*; #(
	parameter int TABLE_POINTS      = 16,
	parameter int READING_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	output logic        result_valid,
	input  logic        result_stall,
	output out_item_t   result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int AW = $clog2(TABLE_POINTS);
	localparam logic [READING_W-1:0] FLOOR_RESET = from_x20(22'd2, READING_FRAC_BITS);

	// Configuration registers
	logic [POINTS_W-1:0]  points_q;
	logic [READING_W-1:0] floor_reading_q;
	logic [VIS_W-1:0]     floor_vis_q;

	// Sequencer
	seq_state_t state_q, state_d;
	div_op_t    op_q, op_d;
	logic [AW-1:0] iss_q;
	logic [AW-1:0] nm1_q;
	logic [AW-1:0] nm1_new;
	logic [AW-1:0] rd_addr;
	logic          rd_vld_q;
	logic [AW-1:0] rd_idx_q;
	logic          accept;

	// Table
	logic       wr_en;
	tbl_entry_t wr_entry;
	tbl_entry_t rd_entry;

	// Divider
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Datapath registers
	logic [READING_W-1:0] x_q;
	logic [AW-1:0]        c_q;
	logic [READING_W-1:0] rc_q;
	logic [VIS_W-1:0]     dc_q;
	logic [READING_W-1:0] r0_q;
	logic [VIS_W-1:0]     d0_q;
	logic [READING_W-1:0] rl_q;
	logic [VIS_W-1:0]     dl_q;
	logic [VIS_W-1:0]     d1_q;
	logic [READING_W-1:0] dps_q;
	logic [READING_W-1:0] span_q;
	logic [DIV_W-1:0]     s0_q;
	logic [DIV_W-1:0]     s1_q;
	logic [31:0]          f_q;
	logic [63:0]          prod_lo_q;
	logic [DIV_W-1:0]     prod_hi_q;
	logic [DIV_W-1:0]     sig_q;
	out_item_t            res_q;
	out_item_t            out_q;
	logic                 out_vld_q;

	logic                 down;
	logic [DIV_W-1:0]     diff_s;
	logic [DIV_W:0]       t_w;
	logic [DIV_W:0]       sig_w;
	logic [DIV_W-1:0]     dc_nz;
	logic [DIV_W-1:0]     d1_nz;

	assign accept     = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q        <= 5'd16;
			floor_reading_q <= FLOOR_RESET;
			floor_vis_q     <= 17'd75000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_POINTS:        points_q        <= cfg_data[POINTS_W-1:0];
				CFG_FLOOR_READING: floor_reading_q <= cfg_data;
				CFG_FLOOR_VIS:     floor_vis_q     <= cfg_data[VIS_W-1:0];
				default:           ;
			endcase
		end
	end

	// Index of the last used entry, with the count clamped to at least two and to the table.
	always_comb begin
		if (points_q < 5'd2) begin
			nm1_new = AW'(1);
		end else if (int'(points_q) > TABLE_POINTS) begin
			nm1_new = AW'(TABLE_POINTS - 1);
		end else begin
			nm1_new = AW'(points_q - 5'd1);
		end
	end

	// Load items write the table in the cycle of their transfer.
	assign wr_en = accept && (item.kind == KIND_LOAD) && (int'(item.entry_index) < TABLE_POINTS);
	assign wr_entry = '{reading: item.entry_reading, distance: item.entry_visibility};

	vti_table #(
		.TABLE_POINTS      (TABLE_POINTS),
		.READING_FRAC_BITS (READING_FRAC_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (AW'(item.entry_index)),
		.wr_entry (wr_entry),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry)
	);

	vti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Divisors for the two sigma values; a zero distance counts as one meter.
	assign dc_nz = (dc_q == '0) ? DIV_W'(1) : DIV_W'(dc_q);
	assign d1_nz = (d1_q == '0) ? DIV_W'(1) : DIV_W'(d1_q);

	// Sigma interpolation arithmetic.
	always_comb begin
		down   = s0_q >= s1_q;
		diff_s = down ? (s0_q - s1_q) : (s1_q - s0_q);
		t_w    = {1'b0, prod_hi_q} + {3'b0, prod_lo_q[63:32]};
		sig_w  = down ? ({1'b0, s0_q} - t_w) : ({1'b0, s0_q} + t_w);
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_SIGMA0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
		end
	end

	// Next state, table read address and divider requests.
	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		rd_addr = iss_q;
		div_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && item.kind == KIND_CONVERT) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (iss_q == nm1_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				rd_addr = (c_q == nm1_q) ? c_q : c_q + 1'b1;
				if (x_q >= r0_q || x_q < floor_reading_q || x_q < rl_q || c_q == nm1_q) begin
					state_d = ST_FINISH;
				end else begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT: begin
				// A segment of zero or negative length keeps the lower-index distance.
				if (rc_q <= rd_entry.reading) begin
					state_d = ST_FINISH;
				end else begin
					op_d    = OP_SIGMA0;
					state_d = ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				div_req.go = 1'b1;
				unique case (op_q)
					OP_SIGMA0: begin
						div_req.num   = SIGMA_NUM;
						div_req.den   = dc_nz;
						div_req.steps = STEPS_SIGMA;
					end
					OP_SIGMA1: begin
						div_req.num   = SIGMA_NUM;
						div_req.den   = d1_nz;
						div_req.steps = STEPS_SIGMA;
					end
					OP_FRAC: begin
						div_req.rem_init = DIV_W'(dps_q);
						div_req.den      = DIV_W'(span_q);
						div_req.steps    = STEPS_FRAC;
					end
					OP_VIS: begin
						div_req.num   = SIGMA_NUM;
						div_req.den   = sig_q;
						div_req.steps = STEPS_SIGMA;
					end
					default: ;
				endcase
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					unique case (op_q)
						OP_SIGMA0: begin
							op_d    = OP_SIGMA1;
							state_d = ST_DIV_GO;
						end
						OP_SIGMA1: begin
							// A reading on the lower entry sits at the end of the segment.
							if (dps_q == span_q) begin
								state_d = ST_MUL;
							end else begin
								op_d    = OP_FRAC;
								state_d = ST_DIV_GO;
							end
						end
						OP_FRAC: state_d = ST_MUL;
						OP_VIS:  state_d = ST_FINISH;
						default: state_d = ST_IDLE;
					endcase
				end
			end
			ST_MUL: begin
				state_d = ST_ADD;
			end
			ST_ADD: begin
				op_d    = OP_VIS;
				state_d = ST_DIV_GO;
			end
			ST_FINISH: begin
				if (!out_vld_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Scan counter and read tracking.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q    <= '0;
			nm1_q    <= AW'(1);
			rd_vld_q <= 1'b0;
			rd_idx_q <= '0;
		end else begin
			rd_vld_q <= (state_q == ST_SCAN);
			rd_idx_q <= iss_q;
			if (accept) begin
				iss_q <= '0;
				nm1_q <= nm1_new;
			end else if (state_q == ST_SCAN && iss_q != nm1_q) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	// Scan results: first and last used entries, and the last entry above the reading.
	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= item.sample_reading;
		end
		if (rd_vld_q) begin
			if (rd_idx_q == '0) begin
				r0_q <= rd_entry.reading;
				d0_q <= rd_entry.distance;
			end
			if (rd_idx_q == '0 || x_q < rd_entry.reading) begin
				c_q  <= rd_idx_q;
				rc_q <= rd_entry.reading;
				dc_q <= rd_entry.distance;
			end
			if (rd_idx_q == nm1_q) begin
				rl_q <= rd_entry.reading;
				dl_q <= rd_entry.distance;
			end
		end
	end

	// Region decision, segment setup and arithmetic steps.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DECIDE: begin
				if (x_q >= r0_q) begin
					res_q <= '{visibility_m: d0_q, region: REG_ABOVE_FIRST};
				end else if (x_q < floor_reading_q) begin
					res_q <= '{visibility_m: floor_vis_q, region: REG_BELOW_FLOOR};
				end else if (x_q < rl_q) begin
					res_q <= '{visibility_m: dl_q, region: REG_BELOW_LAST};
				end else begin
					res_q <= '{visibility_m: dc_q, region: REG_INTERP};
				end
			end
			ST_NEXT: begin
				d1_q   <= rd_entry.distance;
				dps_q  <= rc_q - x_q;
				span_q <= rc_q - rd_entry.reading;
			end
			ST_DIV_WAIT: begin
				if (div_rsp.done) begin
					unique case (op_q)
						OP_SIGMA0: s0_q <= div_rsp.quo;
						OP_SIGMA1: begin
							s1_q <= div_rsp.quo;
							f_q  <= '1;
						end
						OP_FRAC: f_q <= div_rsp.quo[31:0];
						OP_VIS: begin
							res_q.visibility_m <= (div_rsp.quo > DIV_W'(VIS_MAX)) ?
								VIS_MAX : div_rsp.quo[VIS_W-1:0];
						end
						default: ;
					endcase
				end
			end
			ST_MUL: begin
				prod_lo_q <= diff_s[31:0] * f_q;
				prod_hi_q <= {32'd0, diff_s[DIV_W-1:32]} * {2'd0, f_q};
			end
			ST_ADD: begin
				sig_q <= (sig_w[DIV_W-1:0] == '0) ? DIV_W'(1) : sig_w[DIV_W-1:0];
			end
			default: ;
		endcase
	end

	// Result register: holds a finished result until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_FINISH && state_d == ST_IDLE) begin
			out_vld_q <= 1'b1;
		end else if (!result_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && state_d == ST_IDLE) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

endmodule
